[design/pirl_pkg.sv]
package pirl_pkg;

	localparam int CAPACITY_DEF    = 64;
	localparam int ENTRY_WIDTH_DEF = 32;

	localparam int MODE_W   = 3;
	localparam int POS_W    = 7;
	localparam int WORD_W   = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 7;
	localparam int LIMIT_W  = 7;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

	// APB: one register, byte address 4*index
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_CAPACITY_LIMIT = 1'b0;

	// stream packing, zero filled to whole bytes
	localparam int S_TDATA_W = ((POS_W + WORD_W + 7) / 8) * 8;
	localparam int M_TDATA_W = ((WORD_W + COUNT_W + 7) / 8) * 8;

	typedef enum logic [MODE_W-1:0] {
		MODE_INS_FRONT = 3'd0,
		MODE_INS_BACK  = 3'd1,
		MODE_INS_AT    = 3'd2,
		MODE_REM_FRONT = 3'd3,
		MODE_REM_BACK  = 3'd4,
		MODE_REM_AT    = 3'd5
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef struct packed {
		logic load;
		logic eval;
		logic move;
		logic commit;
		logic resp;
	} ctrl_cmd_t;

	typedef struct packed {
		logic go;
		logic move_done;
		logic out_free;
	} dp_sts_t;

endpackage

[design/positional_insert_remove_list_unit.sv]
// Channel   Dir  Width  Contents
// apb       in   32     capacity_limit at byte address 0 (bits 6:0)
// s_*       in   40     tdata: position, entry_in; tuser: mode
// m_*       out  40     tdata: entry_out, entry_count; tuser: status
//
// One request at a time. An accepted request passes EVAL, MOVE, COMMIT and RESP;
// the MOVE sweep covers n = count - at entries. A rejected or unused-mode request
// goes from EVAL straight to RESP. The sweep through the list memory reads one
// word and writes one per cycle.
// Reset clears the count and the control state; list contents are not cleared.
// The result register lets a new request in while the last result waits on
// m_tready; a stalled result holds the unit before its next result.
module positional_insert_remove_list_unit #(
	parameter int CAPACITY    = pirl_pkg::CAPACITY_DEF,
	parameter int ENTRY_WIDTH = pirl_pkg::ENTRY_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [pirl_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [pirl_pkg::APB_DATA_W-1:0] pwdata,
	output logic [pirl_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready,
	// requests
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [pirl_pkg::S_TDATA_W-1:0]  s_tdata,  // position[6:0], entry_in[38:7], pad
	input  logic [pirl_pkg::MODE_W-1:0]     s_tuser,  // mode[2:0]
	// results
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [pirl_pkg::M_TDATA_W-1:0]  m_tdata,  // entry_out[31:0], entry_count[38:32], pad
	output logic [pirl_pkg::STATUS_W-1:0]   m_tuser   // status[1:0]
);

	import pirl_pkg::*;

	localparam int PAD_W = M_TDATA_W - WORD_W - COUNT_W;

	logic [LIMIT_W-1:0]  limit_q;
	logic                cfg_wr;
	ctrl_cmd_t           cmd;
	dp_sts_t             sts;
	logic [WORD_W-1:0]   entry_out;
	logic [STATUS_W-1:0] status;
	logic [COUNT_W-1:0]  entry_count;

	// APB: zero wait, register picked by word index
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready
		&& (paddr[APB_ADDR_W-1] == REG_CAPACITY_LIMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_wr) begin
			limit_q <= pwdata[LIMIT_W-1:0];
		end
	end

	assign prdata = (paddr[APB_ADDR_W-1] == REG_CAPACITY_LIMIT)
		? APB_DATA_W'(limit_q) : '0;

	pirl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pirl_dp #(
		.CAPACITY    (CAPACITY),
		.ENTRY_WIDTH (ENTRY_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.mode        (s_tuser),
		.position    (s_tdata[POS_W-1:0]),
		.entry_in    (s_tdata[POS_W+WORD_W-1:POS_W]),
		.limit       (limit_q),
		.m_tready    (m_tready),
		.m_tvalid    (m_tvalid),
		.entry_out   (entry_out),
		.status      (status),
		.entry_count (entry_count)
	);

	assign m_tdata = {PAD_W'(0), entry_count, entry_out};
	assign m_tuser = status;

	// one request in flight: the unit closes right after a transfer in
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request taken while busy");

	// inserts rejected as full return no word
	a_full_no_word: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == ST_FULL)) |-> (m_tdata[WORD_W-1:0] == '0))
		else $error("full status with nonzero word");

	// empty status only on an empty list
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == ST_EMPTY)) |-> (m_tdata[WORD_W+COUNT_W-1:WORD_W] == '0))
		else $error("empty status with entries held");

	// count stays within storage
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (32'(m_tdata[WORD_W+COUNT_W-1:WORD_W]) <= 32'(CAPACITY)))
		else $error("entry count above capacity");

endmodule

[design/pirl_ram.sv]
module pirl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[design/pirl_ctrl.sv]
module pirl_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  pirl_pkg::dp_sts_t    sts,
	output pirl_pkg::ctrl_cmd_t  cmd
);

	import pirl_pkg::*;

	typedef enum logic [4:0] {
		IDLE   = 5'b00001,
		EVAL   = 5'b00010,
		MOVE   = 5'b00100,
		COMMIT = 5'b01000,
		RESP   = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			IDLE: begin
				if (s_tvalid) state_d = EVAL;
			end
			EVAL: begin
				state_d = sts.go ? MOVE : RESP;
			end
			MOVE: begin
				if (sts.move_done) state_d = COMMIT;
			end
			COMMIT: begin
				state_d = RESP;
			end
			RESP: begin
				if (sts.out_free) state_d = IDLE;
			end
			default: begin
				state_d = IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign s_tready   = (state_q == IDLE);
	assign cmd.load   = (state_q == IDLE) && s_tvalid;
	assign cmd.eval   = (state_q == EVAL);
	assign cmd.move   = (state_q == MOVE);
	assign cmd.commit = (state_q == COMMIT);
	assign cmd.resp   = (state_q == RESP);

endmodule

[design/pirl_dp.sv]
module pirl_dp #(
	parameter int CAPACITY    = pirl_pkg::CAPACITY_DEF,
	parameter int ENTRY_WIDTH = pirl_pkg::ENTRY_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pirl_pkg::ctrl_cmd_t           cmd,
	output pirl_pkg::dp_sts_t             sts,
	input  logic [pirl_pkg::MODE_W-1:0]   mode,
	input  logic [pirl_pkg::POS_W-1:0]    position,
	input  logic [pirl_pkg::WORD_W-1:0]   entry_in,
	input  logic [pirl_pkg::LIMIT_W-1:0]  limit,
	input  logic                          m_tready,
	output logic                          m_tvalid,
	output logic [pirl_pkg::WORD_W-1:0]   entry_out,
	output logic [pirl_pkg::STATUS_W-1:0] status,
	output logic [pirl_pkg::COUNT_W-1:0]  entry_count
);

	import pirl_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = (CW > POS_W) ? CW : POS_W;

	// request, latched at accept
	logic [MODE_W-1:0]      mode_q;
	logic [POS_W-1:0]       pos_q;
	logic [ENTRY_WIDTH-1:0] word_q;
	logic [63:0]            word_wide;

	// list state and sweep control
	logic [CW-1:0]          count_q;
	logic [CW-1:0]          reads_left_q;
	logic [AW-1:0]          idx_q;
	logic                   pend_q;
	logic [AW-1:0]          pend_addr_q;
	logic [AW-1:0]          at_q;
	logic                   ins_q;
	status_t                status_q;
	logic [ENTRY_WIDTH-1:0] removed_q;
	logic [63:0]            removed_wide;

	// output register
	logic                   out_valid_q;
	logic [WORD_W-1:0]      out_word_q;
	logic [STATUS_W-1:0]    out_status_q;
	logic [COUNT_W-1:0]     out_count_q;
	logic                   out_free;

	// request check
	logic [XW-1:0]          count_x, pos_x, lim_x, at_x;
	logic                   is_ins, is_rem;
	status_t                eval_status;
	logic                   go;

	// memory ports
	logic                   ram_we;
	logic [AW-1:0]          ram_waddr;
	logic [ENTRY_WIDTH-1:0] ram_wdata;
	logic                   ram_re;
	logic [ENTRY_WIDTH-1:0] ram_rdata;

	assign word_wide    = 64'(entry_in);
	assign removed_wide = 64'(removed_q);

	assign count_x = XW'(count_q);
	assign pos_x   = XW'(pos_q);
	assign lim_x   = (XW'(limit) > XW'(CAPACITY)) ? XW'(CAPACITY) : XW'(limit);

	always_comb begin
		is_ins = 1'b0;
		is_rem = 1'b0;
		at_x   = '0;
		unique case (mode_q)
			MODE_INS_FRONT: begin
				is_ins = 1'b1;
			end
			MODE_INS_BACK: begin
				is_ins = 1'b1;
				at_x   = count_x;
			end
			MODE_INS_AT: begin
				is_ins = 1'b1;
				at_x   = pos_x;
			end
			MODE_REM_FRONT: begin
				is_rem = 1'b1;
			end
			MODE_REM_BACK: begin
				is_rem = 1'b1;
				at_x   = (count_x == '0) ? '0 : count_x - XW'(1);
			end
			MODE_REM_AT: begin
				is_rem = 1'b1;
				at_x   = pos_x;
			end
			default: begin
				is_ins = 1'b0;
			end
		endcase
	end

	// full/empty checked ahead of range
	always_comb begin
		eval_status = ST_OK;
		if (is_ins) begin
			if (count_x >= lim_x)   eval_status = ST_FULL;
			else if (at_x > count_x) eval_status = ST_RANGE;
		end else if (is_rem) begin
			if (count_x == '0)        eval_status = ST_EMPTY;
			else if (at_x >= count_x) eval_status = ST_RANGE;
		end
	end

	assign go = (is_ins || is_rem) && (eval_status == ST_OK);

	// sweep: insert reads count-1 down to at and writes one up;
	// remove reads at up to count-1, first word is the result, rest move down
	assign ram_re = cmd.move && (reads_left_q != '0);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = at_q;
		ram_wdata = word_q;
		if (cmd.commit && ins_q) begin
			ram_we = 1'b1;
		end else if (cmd.move && pend_q) begin
			ram_wdata = ram_rdata;
			if (ins_q) begin
				ram_we    = 1'b1;
				ram_waddr = pend_addr_q + AW'(1);
			end else if (pend_addr_q != at_q) begin
				ram_we    = 1'b1;
				ram_waddr = pend_addr_q - AW'(1);
			end
		end
	end

	pirl_ram #(
		.WIDTH (ENTRY_WIDTH),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			reads_left_q <= '0;
			idx_q        <= '0;
			pend_q       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.eval) begin
				reads_left_q <= CW'(count_x - at_x);
				idx_q        <= is_ins ? AW'(count_x - XW'(1)) : AW'(at_x);
				pend_q       <= 1'b0;
			end else if (cmd.move) begin
				pend_q <= ram_re;
				if (ram_re) begin
					reads_left_q <= reads_left_q - CW'(1);
					idx_q        <= ins_q ? idx_q - AW'(1) : idx_q + AW'(1);
				end
			end
			if (cmd.commit) begin
				count_q <= ins_q ? count_q + CW'(1) : count_q - CW'(1);
			end
			if (cmd.resp && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			pos_q  <= position;
			word_q <= word_wide[ENTRY_WIDTH-1:0];
		end
		if (cmd.eval) begin
			status_q  <= eval_status;
			ins_q     <= is_ins;
			at_q      <= AW'(at_x);
			removed_q <= '0;
		end
		if (cmd.move) begin
			pend_addr_q <= idx_q;
			if (pend_q && !ins_q && (pend_addr_q == at_q)) begin
				removed_q <= ram_rdata;
			end
		end
		if (cmd.resp && out_free) begin
			out_word_q   <= removed_wide[WORD_W-1:0];
			out_status_q <= status_q;
			out_count_q  <= COUNT_W'(count_q);
		end
	end

	assign sts.go        = go;
	assign sts.move_done = (reads_left_q == '0) && !pend_q;
	assign sts.out_free  = out_free;

	assign m_tvalid    = out_valid_q;
	assign entry_out   = out_word_q;
	assign status      = out_status_q;
	assign entry_count = out_count_q;

endmodule
